// ===== sv/assert_macros.svh =====
// Assertion macros shared by the timestamp sync RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies expr in the same cycle
`define TSS_ASSERT_IMPLY(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");

// Check that cond implies expr in the following cycle
`define TSS_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

// Check that expr holds at every edge out of reset
`define TSS_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

`endif

// ===== sv/tss_pkg.sv =====
// Shared types and constants for the sensor timestamp sync block.
// No dependencies; every other file except assert_macros.svh imports it.
package tss_pkg;

    localparam int TIME_W    = 52;   // sensor and local time
    localparam int OFF_W     = 53;   // signed offset, also window average
    localparam int OUT_W     = 53;   // signed result time
    localparam int T_W       = 55;   // signed working width of corrected time
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROLLBACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUDGE    = 2'd1;

    localparam logic [CFG_W-1:0] ROLLBACK_RESET = 20'd1000;
    localparam logic [CFG_W-1:0] NUDGE_RESET    = 20'd100;

    typedef enum logic [KIND_W-1:0] {
        KIND_IMU    = 3'd0,
        KIND_GNSS   = 3'd1,
        KIND_ASSIGN = 3'd2,
        KIND_QUERY  = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        SYNC_NONE = 2'd0,
        SYNC_ING  = 2'd1,
        SYNC_DONE = 2'd2
    } sync_t;

    typedef enum logic [1:0] {
        ADJ_NONE  = 2'd0,
        ADJ_CLAMP = 2'd1,
        ADJ_NUDGE = 2'd2
    } adj_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WRITE,
        S_DIV,
        S_CALC,
        S_CMP,
        S_EMIT
    } ctl_state_t;

    // Commands from the controller to one offset window
    typedef struct packed {
        logic rd;
        logic push;
        logic clear;
    } win_ctl_t;

endpackage

// ===== sv/tss_sample_if.sv =====
// Request channel of the timestamp sync block: kind, sensor and local time.
// Depends on tss_pkg for field widths.
interface tss_sample_if import tss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [TIME_W-1:0]   sensor_time;
    logic [TIME_W-1:0]   recv_time;

    modport source (output valid, kind, sensor_time, recv_time, input ready);
    modport sink   (input valid, kind, sensor_time, recv_time, output ready);
endinterface

// ===== sv/tss_result_if.sv =====
// Result channel of the timestamp sync block: time, sync state, adjustment.
// Depends on tss_pkg for field widths.
interface tss_result_if import tss_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] time_out;
    logic [1:0]              sync_state;
    logic [1:0]              adjusted;

    modport source (output valid, time_out, sync_state, adjusted, input ready);
    modport sink   (input valid, time_out, sync_state, adjusted, output ready);
endinterface

// ===== sv/tss_cfg_if.sv =====
// Register write channel of the timestamp sync block.
// Depends on tss_pkg for index and data widths.
interface tss_cfg_if import tss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tss_window.sv =====
// Ring window of clock offsets with running sum, write position and fill count.
// Depends on tss_pkg (win_ctl_t, OFF_W) and assert_macros.svh.
`include "assert_macros.svh"

module tss_window import tss_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int SUM_W  = 57,
    parameter int FILL_W = 5,
    parameter int POS_W  = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  win_ctl_t                ctl,
    input  logic signed [OFF_W-1:0] offset,
    output logic signed [SUM_W-1:0] sum,
    output logic [FILL_W-1:0]       fill
);

    logic signed [OFF_W-1:0] mem [DEPTH];
    logic signed [OFF_W-1:0] rd_data_reg;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    full;

    // Write the new offset and fetch the entry it will replace
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[pos_reg] <= offset;
        end
        if (ctl.rd)
        begin
            rd_data_reg <= mem[pos_reg];
        end
    end

    assign full = (fill_reg == FILL_W'(DEPTH));

    // Advance sum, fill and position on a push; drop everything on clear
    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        pos_next  = pos_reg;
        priority if (ctl.clear)
        begin
            sum_next  = '0;
            fill_next = '0;
            pos_next  = '0;
        end
        else if (ctl.push)
        begin
            sum_next  = sum_reg - (full ? SUM_W'(rd_data_reg) : SUM_W'(0))
                        + SUM_W'(offset);
            fill_next = full ? fill_reg : fill_reg + 1'b1;
            pos_next  = (pos_reg == POS_W'(DEPTH - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            fill_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

    `TSS_ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_reg <= FILL_W'(DEPTH))
    `TSS_ASSERT_NEXT(a_fill_grows, clk, rst_n, ctl.push && !ctl.clear && !full, fill_reg == $past(fill_reg) + 1'b1)
    `TSS_ASSERT_NEXT(a_clear_empties, clk, rst_n, ctl.clear, sum_reg == '0 && fill_reg == '0 && pos_reg == '0)

endmodule

// ===== sv/tss_divider.sv =====
// Bit-serial restoring divider: signed window sum over fill count, toward zero.
// Depends on tss_pkg only through the shared import convention.
module tss_divider import tss_pkg::*; #(
    parameter int SUM_W  = 57,
    parameter int FILL_W = 5
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [SUM_W-1:0] dividend,
    input  logic [FILL_W-1:0]       divisor,
    output logic                    done,
    output logic signed [SUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [FILL_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]        quo_reg, quo_next;
    logic [FILL_W-1:0]       div_reg, div_next;
    logic                    neg_reg, neg_next;
    logic                    zero_reg, zero_next;
    logic signed [SUM_W-1:0] res_reg, res_next;

    logic [FILL_W:0]         trial;
    logic                    fits;

    // Shift in one dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        res_next  = res_reg;
        priority if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CNT_W'(SUM_W);
            rem_next  = '0;
            quo_next  = dividend[SUM_W-1] ? 0 - dividend : dividend;
            div_next  = divisor;
            neg_next  = dividend[SUM_W-1];
            zero_next = (divisor == '0);
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? FILL_W'(trial - {1'b0, div_reg}) : trial[FILL_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
        end
        else if (busy_reg)
        begin
            // Restore the sign; an empty window averages to zero
            busy_next = 1'b0;
            done_next = 1'b1;
            res_next  = zero_reg ? '0 : (neg_reg ? 0 - quo_reg : quo_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
        res_reg  <= res_next;
    end

    assign done     = done_reg;
    assign quotient = res_reg;

endmodule

// ===== sv/sensor_timestamp_sync.sv =====
// Channel   | dir | payload                              | handshake
// sample    | in  | kind, sensor_time, recv_time         | valid / ready
// result    | out | time_out, sync_state, adjusted       | valid / ready
// cfg       | in  | index, data (threshold, nudge)       | valid / ready (always ready)
//
// One request at a time. An update runs through accept, window read, window write and
// result load; clear and unknown kinds go from accept straight to result load. Assign
// and query run both window averages through bit-serial dividers of width SUM_W =
// 53 + log2(depth). Reset empties both windows and loads threshold 1000 and
// nudge 100. A stalled result sits in the output register; the next request is
// taken meanwhile and waits in its last step until the register frees.
// Depends on tss_pkg, the three channel interfaces, tss_window and tss_divider.
`include "assert_macros.svh"

module sensor_timestamp_sync import tss_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    tss_sample_if.sink   sample,
    tss_result_if.source result,
    tss_cfg_if.sink      cfg
);

    localparam int SUM_W  = OFF_W + $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    ctl_state_t state_reg, state_next;

    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [TIME_W-1:0]       sensor_reg, sensor_next;
    logic [TIME_W-1:0]       local_reg, local_next;
    logic signed [OFF_W-1:0] off_reg, off_next;
    logic                    gnss_ok_reg, gnss_ok_next;
    logic signed [T_W-1:0]   res_reg, res_next;
    adj_t                    adj_reg, adj_next;

    sync_t                   status_reg, status_next;
    logic [TIME_W-1:0]       last_imu_reg, last_imu_next;
    logic [TIME_W-1:0]       last_gnss_reg, last_gnss_next;
    logic [CFG_W-1:0]        thr_reg, nudge_reg;

    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_time_reg, out_time_next;
    logic [1:0]              out_sync_reg, out_sync_next;
    logic [1:0]              out_adj_reg, out_adj_next;

    logic                    accept;
    logic                    out_free;
    logic                    div_start;
    win_ctl_t                imu_ctl, gnss_ctl;

    logic signed [SUM_W-1:0] imu_sum, gnss_sum;
    logic [FILL_W-1:0]       imu_fill, gnss_fill;
    logic                    imu_done, gnss_done;
    logic signed [SUM_W-1:0] imu_quo, gnss_quo;
    logic signed [OFF_W-1:0] imu_avg, gnss_avg;

    logic signed [T_W-1:0]   gnss_term;
    logic signed [T_W-1:0]   ref_time, ref_low, ref_nudged;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    // Offset windows
    tss_window #(
        .DEPTH  (WINDOW_DEPTH),
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W),
        .POS_W  (POS_W)
    ) u_imu_win (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (imu_ctl),
        .offset (off_reg),
        .sum    (imu_sum),
        .fill   (imu_fill)
    );

    tss_window #(
        .DEPTH  (WINDOW_DEPTH),
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W),
        .POS_W  (POS_W)
    ) u_gnss_win (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (gnss_ctl),
        .offset (off_reg),
        .sum    (gnss_sum),
        .fill   (gnss_fill)
    );

    // Window averages, both computed in parallel
    tss_divider #(
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W)
    ) u_imu_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (imu_sum),
        .divisor  (imu_fill),
        .done     (imu_done),
        .quotient (imu_quo)
    );

    tss_divider #(
        .SUM_W  (SUM_W),
        .FILL_W (FILL_W)
    ) u_gnss_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (gnss_sum),
        .divisor  (gnss_fill),
        .done     (gnss_done),
        .quotient (gnss_quo)
    );

    assign imu_avg  = imu_quo[OFF_W-1:0];
    assign gnss_avg = gnss_quo[OFF_W-1:0];

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (sample.kind == KIND_IMU || sample.kind == KIND_GNSS)
                    begin
                        state_next = S_READ;
                    end
                    else if (sample.kind == KIND_ASSIGN || sample.kind == KIND_QUERY)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = S_EMIT;
            S_DIV:
            begin
                if (imu_done && gnss_done)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:  state_next = S_CMP;
            S_CMP:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        sample.ready   = (state_reg == S_IDLE);
        div_start      = accept &&
                         (sample.kind == KIND_ASSIGN || sample.kind == KIND_QUERY);
        imu_ctl.rd     = (state_reg == S_READ)  && (kind_reg == KIND_IMU);
        imu_ctl.push   = (state_reg == S_WRITE) && (kind_reg == KIND_IMU);
        imu_ctl.clear  = accept && (sample.kind == KIND_CLEAR);
        gnss_ctl.rd    = (state_reg == S_READ)  && (kind_reg == KIND_GNSS);
        gnss_ctl.push  = (state_reg == S_WRITE) && (kind_reg == KIND_GNSS);
        gnss_ctl.clear = accept && (sample.kind == KIND_CLEAR);
    end

    // Corrected-time terms
    assign gnss_term  = gnss_ok_reg ? T_W'(gnss_avg) : T_W'(0);
    assign ref_time   = gnss_ok_reg ? $signed(T_W'(last_gnss_reg))
                                    : $signed(T_W'(last_imu_reg));
    assign ref_low    = ref_time - $signed(T_W'(thr_reg));
    assign ref_nudged = ref_time + $signed(T_W'(nudge_reg));

    // Datapath and state updates
    always_comb
    begin
        kind_next      = kind_reg;
        sensor_next    = sensor_reg;
        local_next     = local_reg;
        off_next       = off_reg;
        gnss_ok_next   = gnss_ok_reg;
        res_next       = res_reg;
        adj_next       = adj_reg;
        status_next    = status_reg;
        last_imu_next  = last_imu_reg;
        last_gnss_next = last_gnss_reg;
        out_valid_next = out_valid_reg;
        out_time_next  = out_time_reg;
        out_sync_next  = out_sync_reg;
        out_adj_next   = out_adj_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Hold the request and its offset
                    kind_next    = sample.kind;
                    sensor_next  = sample.sensor_time;
                    local_next   = sample.recv_time;
                    off_next     = $signed({1'b0, sample.sensor_time})
                                   - $signed({1'b0, sample.recv_time});
                    gnss_ok_next = (status_reg == SYNC_DONE) && (gnss_fill != '0);
                    res_next     = '0;
                    adj_next     = ADJ_NONE;
                    if (sample.kind == KIND_CLEAR)
                    begin
                        status_next    = SYNC_NONE;
                        last_imu_next  = '0;
                        last_gnss_next = '0;
                    end
                end
            end
            S_READ:
            begin
            end
            S_WRITE:
            begin
                res_next = T_W'(off_reg);
                if (kind_reg == KIND_IMU)
                begin
                    last_imu_next = sensor_reg;
                    if (status_reg == SYNC_NONE)
                    begin
                        status_next = SYNC_ING;
                    end
                end
                else
                begin
                    last_gnss_next = sensor_reg;
                    status_next    = SYNC_DONE;
                end
            end
            S_DIV:
            begin
            end
            S_CALC:
            begin
                if (kind_reg == KIND_ASSIGN)
                begin
                    res_next = $signed(T_W'(sensor_reg)) - T_W'(imu_avg) + gnss_term;
                end
                else
                begin
                    res_next = $signed(T_W'(local_reg)) + gnss_term;
                end
            end
            S_CMP:
            begin
                // Clamp or nudge a stamp that falls behind the reference
                if (kind_reg == KIND_ASSIGN)
                begin
                    priority if (res_reg < ref_low)
                    begin
                        res_next = ref_nudged;
                        adj_next = ADJ_NUDGE;
                    end
                    else if (res_reg < ref_time)
                    begin
                        res_next = ref_time;
                        adj_next = ADJ_CLAMP;
                    end
                    else
                    begin
                        res_next = res_reg;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    // Saturate into the result width
                    out_valid_next = 1'b1;
                    if (res_reg[T_W-1:OUT_W-1] == '0 || res_reg[T_W-1:OUT_W-1] == '1)
                    begin
                        out_time_next = res_reg[OUT_W-1:0];
                    end
                    else if (res_reg[T_W-1])
                    begin
                        out_time_next = {1'b1, {(OUT_W-1){1'b0}}};
                    end
                    else
                    begin
                        out_time_next = {1'b0, {(OUT_W-1){1'b1}}};
                    end
                    out_sync_next = status_reg;
                    out_adj_next  = adj_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= SYNC_NONE;
            last_imu_reg  <= '0;
            last_gnss_reg <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= ROLLBACK_RESET;
            nudge_reg     <= NUDGE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            last_imu_reg  <= last_imu_next;
            last_gnss_reg <= last_gnss_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_ROLLBACK)
                begin
                    thr_reg <= cfg.data;
                end
                else if (cfg.index == CFG_NUDGE)
                begin
                    nudge_reg <= cfg.data;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        sensor_reg   <= sensor_next;
        local_reg    <= local_next;
        off_reg      <= off_next;
        gnss_ok_reg  <= gnss_ok_next;
        res_reg      <= res_next;
        adj_reg      <= adj_next;
        out_time_reg <= out_time_next;
        out_sync_reg <= out_sync_next;
        out_adj_reg  <= out_adj_next;
    end

    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.time_out   = out_time_reg;
    assign result.sync_state = out_sync_reg;
    assign result.adjusted   = out_adj_reg;

    `TSS_ASSERT_IMPLY(a_clear_unsynced, clk, rst_n, state_reg == S_EMIT && kind_reg == KIND_CLEAR, status_reg == SYNC_NONE)
    `TSS_ASSERT_IMPLY(a_gnss_synced, clk, rst_n, state_reg == S_EMIT && kind_reg == KIND_GNSS, status_reg == SYNC_DONE)
    `TSS_ASSERT_IMPLY(a_adj_assign_only, clk, rst_n, state_reg == S_EMIT && kind_reg != KIND_ASSIGN, adj_reg == ADJ_NONE)

endmodule

// ===== tb/sensor_timestamp_sync_tb.sv =====
// Self-checking testbench for sensor_timestamp_sync: directed corner requests, then
// random sync sessions under several idle/stall and register settings.
// Depends on tss_pkg, the three channel interfaces and the sensor_timestamp_sync RTL.
`timescale 1ns / 1ps

module sensor_timestamp_sync_tb;
    import tss_pkg::*;

    localparam int     DEPTH       = 16;
    localparam int     SRC_IMU     = 0;
    localparam int     SRC_GNSS    = 1;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     PHASES      = 5;
    localparam int     PHASE_ITEMS = 215;
    localparam int     DRAIN_WAIT  = 80;
    localparam longint OUT_MAX     = (longint'(1) <<< TIME_W) - 1;
    localparam longint OUT_MIN     = -OUT_MAX - 1;
    localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] sens_time;
        logic [TIME_W-1:0] loc_time;
    } sample_item_t;

    typedef struct {
        logic signed [OUT_W-1:0] time_out;
        logic [1:0]              sync_state;
        logic [1:0]              adjusted;
    } stamp_result_t;

    logic clk;
    logic rst_n;

    tss_sample_if sample_ch ();
    tss_result_if result_ch ();
    tss_cfg_if    cfg_ch ();

    sensor_timestamp_sync #(.WINDOW_DEPTH(DEPTH)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    sample_item_t  pend_q[$];
    stamp_result_t expected_q[$];
    int            n_errors = 0;
    int            cycle_count = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;

    // Offset estimator state, one window per source
    longint win_vals [2][DEPTH];
    longint win_sum  [2];
    int     win_pos  [2];
    int     win_fill [2];
    longint last_time[2];
    sync_t  sync_st;
    longint thr_us;
    longint nudge_amt;

    function automatic void clear_estimator();
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < DEPTH; i++)
                win_vals[s][i] = 0;
            win_sum[s]   = 0;
            win_pos[s]   = 0;
            win_fill[s]  = 0;
            last_time[s] = 0;
        end
        sync_st = SYNC_NONE;
    endfunction

    // Push one offset, dropping the oldest entry once the window is full
    function automatic void push_offset(int src, longint value);
        if (win_fill[src] >= DEPTH)
            win_sum[src] -= win_vals[src][win_pos[src]];
        else
            win_fill[src]++;
        win_vals[src][win_pos[src]] = value;
        win_sum[src] += value;
        win_pos[src] = (win_pos[src] + 1 >= DEPTH) ? 0 : win_pos[src] + 1;
    endfunction

    // Window mean, truncated toward zero
    function automatic longint window_mean(int src);
        if (win_fill[src] == 0)
            return 0;
        return win_sum[src] / longint'(win_fill[src]);
    endfunction

    // Advance the estimator by one request and return the expected response
    function automatic stamp_result_t sync_step(sample_item_t it);
        longint        s;
        longint        l;
        longint        t;
        longint        ref_t;
        logic [63:0]   tv;
        bit            gnss_ok;
        stamp_result_t r;
        s = {12'd0, it.sens_time};
        l = {12'd0, it.loc_time};
        t = 0;
        r.adjusted = ADJ_NONE;
        gnss_ok = (sync_st == SYNC_DONE) && (win_fill[SRC_GNSS] != 0);
        case (it.kind)
            KIND_IMU:
            begin
                t = s - l;
                push_offset(SRC_IMU, t);
                last_time[SRC_IMU] = s;
                if (sync_st == SYNC_NONE)
                    sync_st = SYNC_ING;
            end
            KIND_GNSS:
            begin
                t = s - l;
                push_offset(SRC_GNSS, t);
                last_time[SRC_GNSS] = s;
                sync_st = SYNC_DONE;
            end
            KIND_ASSIGN:
            begin
                t = s - window_mean(SRC_IMU);
                if (gnss_ok)
                begin
                    t += window_mean(SRC_GNSS);
                    ref_t = last_time[SRC_GNSS];
                end
                else
                    ref_t = last_time[SRC_IMU];
                // Hold the stamp at or past the reference time
                if (t < ref_t - thr_us)
                begin
                    t = ref_t + nudge_amt;
                    r.adjusted = ADJ_NUDGE;
                end
                else if (t < ref_t)
                begin
                    t = ref_t;
                    r.adjusted = ADJ_CLAMP;
                end
            end
            KIND_QUERY:
            begin
                t = l;
                if (gnss_ok)
                    t += window_mean(SRC_GNSS);
            end
            KIND_CLEAR:
                clear_estimator();
            default:
                t = 0;
        endcase
        if (t > OUT_MAX)
            t = OUT_MAX;
        else if (t < OUT_MIN)
            t = OUT_MIN;
        tv = t;
        r.time_out   = tv[OUT_W-1:0];
        r.sync_state = sync_st;
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: accept, predict, then load the next pending request
    always @(posedge clk)
    begin
        sample_item_t nxt;
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
                expected_q.push_back(sync_step('{sample_ch.kind, sample_ch.sensor_time,
                                                 sample_ch.recv_time}));
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = pend_q.pop_front();
                    sample_ch.valid       <= 1'b1;
                    sample_ch.kind        <= nxt.kind;
                    sample_ch.sensor_time <= nxt.sens_time;
                    sample_ch.recv_time   <= nxt.loc_time;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: compare against the oldest expected response
    always @(posedge clk)
    begin
        stamp_result_t exp_r;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected response: time_out %0d", result_ch.time_out);
                    n_errors++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result_ch.time_out !== exp_r.time_out)
                    begin
                        $error("time_out: expected %0d, got %0d",
                               exp_r.time_out, result_ch.time_out);
                        n_errors++;
                    end
                    if (result_ch.sync_state !== exp_r.sync_state)
                    begin
                        $error("sync_state: expected %0d, got %0d",
                               exp_r.sync_state, result_ch.sync_state);
                        n_errors++;
                    end
                    if (result_ch.adjusted !== exp_r.adjusted)
                    begin
                        $error("adjusted: expected %0d, got %0d",
                               exp_r.adjusted, result_ch.adjusted);
                        n_errors++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic void add_item(logic [KIND_W-1:0] k, logic [TIME_W-1:0] s,
                                     logic [TIME_W-1:0] l);
        pend_q.push_back('{k, s, l});
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // Clip a working time into the unsigned 52-bit field
    function automatic logic [TIME_W-1:0] fit_time(longint v);
        logic [63:0] w;
        if (v < 0)
            return '0;
        if (v > OUT_MAX)
            return TIME_MAX;
        w = v;
        return w[TIME_W-1:0];
    endfunction

    function automatic longint rand_offset();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return longint'($urandom_range(10000)) - 5000;
        else if (pick < 80)
            return longint'($urandom) - longint'($urandom);
        return longint'(rand_time() >> 1) - longint'(rand_time() >> 1);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_ROLLBACK)
            thr_us = value;
        else if (idx == CFG_NUDGE)
            nudge_amt = value;
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || sample_ch.valid || expected_q.size() != 0)
            @(posedge clk);
    endtask

    // One sync session: updates around a drifting local clock, assigns aimed
    // near the rollback threshold, some queries, a little noise
    function automatic int queue_session(int n_items);
        longint lt;
        longint oi;
        longint og;
        longint imu_s;
        longint d;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 30)
            lt = $urandom_range(100000);
        else if (pick < 50)
            lt = OUT_MAX - $urandom_range(1000000);
        else
            lt = rand_time();
        oi = rand_offset();
        og = rand_offset();
        imu_s = fit_time(lt + oi);
        if ($urandom_range(1))
            add_item(KIND_CLEAR, rand_time(), rand_time());
        for (int i = 0; i < n_items; i++)
        begin
            lt = fit_time(lt + $urandom_range(2000));
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                imu_s = fit_time(lt + oi + $urandom_range(100) - 50);
                add_item(KIND_IMU, imu_s, lt);
            end
            else if (pick < 55)
                add_item(KIND_GNSS, fit_time(lt + og + $urandom_range(100) - 50), lt);
            else if (pick < 85)
            begin
                d = longint'($urandom_range(3 * thr_us + 400)) - 2 * thr_us - 200;
                add_item(KIND_ASSIGN, fit_time(imu_s + d), rand_time());
            end
            else if (pick < 95)
                add_item(KIND_QUERY, rand_time(), lt);
            else if (pick < 96)
                add_item(KIND_CLEAR, rand_time(), rand_time());
            else if (pick < 97)
                add_item(KIND_W'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO)),
                         rand_time(), rand_time());
            else
                add_item(KIND_W'($urandom_range(KIND_CLEAR, KIND_IMU)),
                         rand_time(), rand_time());
        end
        return n_items + 1;
    endfunction

    // Stimulus and end of test
    initial
    begin : stimulus
        int queued;
        rst_n = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.kind        = '0;
        sample_ch.sensor_time = '0;
        sample_ch.recv_time   = '0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        clear_estimator();
        thr_us    = ROLLBACK_RESET;
        nudge_amt = NUDGE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners under the reset register values
        add_item(KIND_QUERY, rand_time(), TIME_MAX);
        add_item(KIND_ASSIGN, '0, rand_time());
        add_item(KIND_UNUSED_LO, rand_time(), rand_time());
        add_item(KIND_IMU, TIME_MAX, '0);
        add_item(KIND_IMU, '0, TIME_MAX);
        add_item(KIND_ASSIGN, TIME_MAX, '0);
        add_item(KIND_IMU, TIME_MAX, '0);
        add_item(KIND_ASSIGN, '0, '0);
        add_item(KIND_GNSS, TIME_MAX, '0);
        add_item(KIND_QUERY, '0, TIME_MAX);
        add_item(KIND_ASSIGN, 52'd12345, '0);
        add_item(KIND_CLEAR, TIME_MAX, TIME_MAX);
        add_item(KIND_IMU, 52'd5000, 52'd1000);
        add_item(KIND_ASSIGN, 52'd8500, '0);
        add_item(KIND_ASSIGN, 52'd9500, '0);
        add_item(KIND_ASSIGN, 52'd9000, '0);
        add_item(KIND_ASSIGN, 52'd8000, '0);
        add_item(KIND_ASSIGN, 52'd7999, '0);
        add_item(KIND_GNSS, 52'd3000, 52'd1000);
        add_item(KIND_ASSIGN, 52'd5000, '0);
        add_item(KIND_QUERY, '0, 52'd100);
        add_item(KIND_IMU, '0, 52'd7);
        add_item(KIND_GNSS, '0, 52'd4005);
        add_item(KIND_QUERY, '0, 52'd10000);
        add_item(KIND_UNUSED_HI, TIME_MAX, TIME_MAX);
        wait_drained();

        // Random phases; drain fully before every register change
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_ROLLBACK, '0);
                    write_reg(CFG_NUDGE, '0);
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    write_reg(CFG_ROLLBACK, 20'd1000000);
                    write_reg(CFG_NUDGE, 20'd1000000);
                    src_idle_pct = 80;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    write_reg(CFG_ROLLBACK, CFG_W'($urandom_range(1000000)));
                    write_reg(CFG_NUDGE, CFG_W'($urandom_range(1000000)));
                    src_idle_pct = 0;
                    sink_stall_pct = 80;
                end
                3:
                begin
                    write_reg(CFG_ROLLBACK, ROLLBACK_RESET);
                    write_reg(CFG_NUDGE, NUDGE_RESET);
                    src_idle_pct = 20;
                    sink_stall_pct = 20;
                end
                default:
                begin
                    write_reg(CFG_NUDGE, CFG_W'($urandom_range(5000)));
                    write_reg(CFG_ROLLBACK, CFG_W'($urandom_range(5000)));
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
            endcase
            queued = 0;
            while (queued < PHASE_ITEMS)
                queued += queue_session($urandom_range(90, 20));
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
